>>> sv/sensor_reading_compensation_core_macros.svh
// Assertion helpers, clocked on i_clk, disabled in reset.
`ifndef SENSOR_READING_COMPENSATION_CORE_MACROS_SVH
`define SENSOR_READING_COMPENSATION_CORE_MACROS_SVH

`define SRCC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SRCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/srcc_pkg.sv
`default_nettype none
package srcc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_MULW,
        ST_DIVW,
        ST_FIN,
        ST_OUT
    } t_state;

    localparam logic [1:0] KIND_TEMP  = 2'd0;
    localparam logic [1:0] KIND_PRESS = 2'd1;
    localparam logic [1:0] KIND_HUM   = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    localparam logic [2:0] REG_TEMP    = 3'd0;
    localparam logic [2:0] REG_PRESS_A = 3'd1;
    localparam logic [2:0] REG_PRESS_B = 3'd2;
    localparam logic [2:0] REG_PRESS_C = 3'd3;
    localparam logic [2:0] REG_HUM_A   = 3'd4;
    localparam logic [2:0] REG_HUM_B   = 3'd5;

    localparam logic [3:0] PC_TEMP_LAST   = 4'd3;
    localparam logic [3:0] PC_HUM_LAST    = 4'd7;
    localparam logic [3:0] PC_PRESS_CHECK = 4'd5;
    localparam logic [3:0] PC_PRESS_DIV   = 4'd6;
    localparam logic [3:0] PC_PRESS_LAST  = 4'd9;

    localparam logic [31:0] TEMP_MUL   = 32'd5;
    localparam logic [31:0] TEMP_RND   = 32'd128;
    localparam logic [31:0] HUM_T_OFFS = 32'd76800;
    localparam logic [31:0] HUM_RND_A  = 32'd16384;
    localparam logic [31:0] HUM_OFFS_C = 32'd32768;
    localparam logic [31:0] HUM_OFFS_B = 32'd2097152;
    localparam logic [31:0] HUM_RND_B  = 32'd8192;
    localparam logic [31:0] HUM_MAX    = 32'd419430400;
    localparam logic [63:0] PRS_T_OFFS = 64'd128000;
    localparam logic [63:0] PRS_BASE   = 64'd1048576;
    localparam logic [63:0] PRS_SCALE  = 64'd3125;
    localparam logic [63:0] PRS_BIAS   = 64'h0000_8000_0000_0000;

    function automatic logic [63:0] sx8(input logic [7:0] x);
        return {{56{x[7]}}, x};
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic logic [63:0] sx32(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
        return 64'($signed(x) >>> n);
    endfunction

endpackage
`default_nettype wire

>>> sv/sensor_reading_compensation_core.sv
// Temperature, humidity and pressure are each computed as a sequence of multiplies
// on the shared 32x32 multiplier; the reserved kind goes straight to the output.
// Pressure adds a divide, skipped when the divisor is zero. One request at a time;
// the next is taken the cycle after a result enters the output register, where it
// waits while that request runs.
// Synchronous active-low reset clears control, coefficients and fine temp.
`default_nettype none
`include "sensor_reading_compensation_core_macros.svh"
module sensor_reading_compensation_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic        [1:0]  i_kind,
    input  wire logic        [19:0] i_raw_sample,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic             [1:0]  o_measure_kind,
    output logic signed      [31:0] o_value,
    output logic                    o_invalid,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic        [2:0]  i_cfg_index,
    input  wire logic        [47:0] i_cfg_data
);
    srcc_pkg::t_state r_state, n_state;
    logic [1:0]  r_kind, n_kind;
    logic [19:0] r_raw, n_raw;
    logic [3:0]  r_pc, n_pc;
    logic [31:0] r_ft, n_ft;
    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic [63:0] r_c, n_c;
    logic [63:0] r_n, n_n;
    logic [63:0] r_sq, n_sq;
    logic [31:0] r_val, n_val;
    logic        r_bad, n_bad;
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_out_kind, n_out_kind;
    logic [31:0] r_out_val, n_out_val;
    logic        r_out_bad, n_out_bad;

    logic [47:0] r_cf_t, r_cf_pa, r_cf_pb, r_cf_pc;
    logic [31:0] r_cf_ha;
    logic [39:0] r_cf_hb;

    logic        in_acc;
    logic        mul_start, mul_done;
    logic [63:0] m_a, m_b, mul_prod;
    logic        div_start, div_done;
    logic [63:0] div_q;
    logic        last_step;
    logic        out_move;

    logic [63:0] t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] h1, h2, h3, h5, h6;
    logic [31:0] tx32, ty32, hv32, p32, hum_v;
    logic [63:0] pv1, pp, p_div, prs_t;
    logic [31:0] prs_sat;

    assign t2 = srcc_pkg::sx16(r_cf_t[31:16]);
    assign t3 = srcc_pkg::sx16(r_cf_t[47:32]);
    assign p1 = {48'd0, r_cf_pa[15:0]};
    assign p2 = srcc_pkg::sx16(r_cf_pa[31:16]);
    assign p3 = srcc_pkg::sx16(r_cf_pa[47:32]);
    assign p4 = srcc_pkg::sx16(r_cf_pb[15:0]);
    assign p5 = srcc_pkg::sx16(r_cf_pb[31:16]);
    assign p6 = srcc_pkg::sx16(r_cf_pb[47:32]);
    assign p7 = srcc_pkg::sx16(r_cf_pc[15:0]);
    assign p8 = srcc_pkg::sx16(r_cf_pc[31:16]);
    assign p9 = srcc_pkg::sx16(r_cf_pc[47:32]);
    assign h1 = {56'd0, r_cf_ha[7:0]};
    assign h2 = srcc_pkg::sx16(r_cf_ha[23:8]);
    assign h3 = {56'd0, r_cf_ha[31:24]};
    assign h5 = srcc_pkg::sx16(r_cf_hb[31:16]);
    assign h6 = srcc_pkg::sx8(r_cf_hb[39:32]);

    assign tx32 = {15'd0, r_raw[19:3]} - {15'd0, r_cf_t[15:0], 1'b0};
    assign ty32 = {16'd0, r_raw[19:4]} - {16'd0, r_cf_t[15:0]};
    assign hv32 = r_ft - srcc_pkg::HUM_T_OFFS;
    assign pv1  = srcc_pkg::sx32(r_ft) - srcc_pkg::PRS_T_OFFS;
    assign pp   = srcc_pkg::PRS_BASE - {44'd0, r_raw};
    assign p32  = mul_prod[31:0];
    assign p_div = srcc_pkg::asr64(mul_prod, 33);
    assign hum_v = r_a[31:0] - srcc_pkg::asr32(p32, 4);
    assign prs_t = srcc_pkg::asr64(r_c, 8) + {p7[59:0], 4'd0};
    assign prs_sat = ((prs_t[63:31] == '0) || (prs_t[63:31] == '1)) ? prs_t[31:0]
                   : (prs_t[63] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    assign in_acc   = i_valid && !o_stall;
    assign out_move = (r_state == srcc_pkg::ST_OUT) && (!r_out_valid || !i_stall);

    always_comb begin
        case (r_kind)
            srcc_pkg::KIND_TEMP: last_step = (r_pc == srcc_pkg::PC_TEMP_LAST);
            srcc_pkg::KIND_HUM:  last_step = (r_pc == srcc_pkg::PC_HUM_LAST);
            default:             last_step = 1'b0;
        endcase
    end

    srcc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (m_a),
        .i_b     (m_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    srcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mul_prod),
        .i_den   (r_a),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srcc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_kind == srcc_pkg::KIND_RSVD) ? srcc_pkg::ST_OUT
                                                              : srcc_pkg::ST_ISSUE;
                end
            end
            srcc_pkg::ST_ISSUE: begin
                n_state = srcc_pkg::ST_MULW;
            end
            srcc_pkg::ST_MULW: begin
                if (mul_done) begin
                    if (last_step) begin
                        n_state = srcc_pkg::ST_OUT;
                    end else if (r_kind == srcc_pkg::KIND_PRESS &&
                                 r_pc == srcc_pkg::PC_PRESS_CHECK && p_div == 64'd0) begin
                        n_state = srcc_pkg::ST_OUT;
                    end else if (r_kind == srcc_pkg::KIND_PRESS &&
                                 r_pc == srcc_pkg::PC_PRESS_DIV) begin
                        n_state = srcc_pkg::ST_DIVW;
                    end else if (r_kind == srcc_pkg::KIND_PRESS &&
                                 r_pc == srcc_pkg::PC_PRESS_LAST) begin
                        n_state = srcc_pkg::ST_FIN;
                    end else begin
                        n_state = srcc_pkg::ST_ISSUE;
                    end
                end
            end
            srcc_pkg::ST_DIVW: begin
                if (div_done) begin
                    n_state = srcc_pkg::ST_ISSUE;
                end
            end
            srcc_pkg::ST_FIN: begin
                n_state = srcc_pkg::ST_OUT;
            end
            srcc_pkg::ST_OUT: begin
                if (out_move) begin
                    n_state = srcc_pkg::ST_IDLE;
                end
            end
            default: n_state = srcc_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_stall   = (r_state != srcc_pkg::ST_IDLE);
        mul_start = (r_state == srcc_pkg::ST_ISSUE);
        div_start = (r_state == srcc_pkg::ST_MULW) && mul_done &&
                    (r_kind == srcc_pkg::KIND_PRESS) && (r_pc == srcc_pkg::PC_PRESS_DIV);
    end

    // multiplier operand select
    always_comb begin
        m_a = 64'd0;
        m_b = 64'd0;
        case (r_kind)
            srcc_pkg::KIND_TEMP: begin
                case (r_pc)
                    4'd0:    begin m_a = srcc_pkg::sx32(tx32); m_b = t2; end
                    4'd1:    begin m_a = srcc_pkg::sx32(ty32); m_b = srcc_pkg::sx32(ty32); end
                    4'd2:    begin m_a = srcc_pkg::sx32(r_b[31:0]); m_b = t3; end
                    default: begin
                        m_a = srcc_pkg::sx32(r_ft);
                        m_b = {32'd0, srcc_pkg::TEMP_MUL};
                    end
                endcase
            end
            srcc_pkg::KIND_HUM: begin
                case (r_pc)
                    4'd0:    begin m_a = srcc_pkg::sx32(hv32); m_b = h5; end
                    4'd1:    begin m_a = srcc_pkg::sx32(hv32); m_b = h6; end
                    4'd2:    begin m_a = srcc_pkg::sx32(hv32); m_b = h3; end
                    4'd3:    begin
                        m_a = srcc_pkg::sx32(r_b[31:0]);
                        m_b = srcc_pkg::sx32(r_c[31:0]);
                    end
                    4'd4:    begin m_a = srcc_pkg::sx32(r_b[31:0]); m_b = h2; end
                    4'd5:    begin
                        m_a = srcc_pkg::sx32(r_a[31:0]);
                        m_b = srcc_pkg::sx32(r_b[31:0]);
                    end
                    4'd6:    begin
                        m_a = srcc_pkg::sx32(r_b[31:0]);
                        m_b = srcc_pkg::sx32(r_b[31:0]);
                    end
                    default: begin m_a = srcc_pkg::sx32(r_b[31:0]); m_b = h1; end
                endcase
            end
            default: begin
                case (r_pc)
                    4'd0:    begin m_a = pv1;  m_b = pv1; end
                    4'd1:    begin m_a = r_sq; m_b = p6; end
                    4'd2:    begin m_a = pv1;  m_b = p5; end
                    4'd3:    begin m_a = r_sq; m_b = p3; end
                    4'd4:    begin m_a = pv1;  m_b = p2; end
                    4'd5:    begin m_a = r_a;  m_b = p1; end
                    4'd6:    begin m_a = r_n;  m_b = srcc_pkg::PRS_SCALE; end
                    4'd7:    begin m_a = p9;   m_b = r_sq; end
                    4'd8:    begin m_a = r_b;  m_b = r_sq; end
                    default: begin m_a = p8;   m_b = r_n; end
                endcase
            end
        endcase
    end

    // datapath
    always_comb begin
        n_kind      = r_kind;
        n_raw       = r_raw;
        n_pc        = r_pc;
        n_ft        = r_ft;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_n         = r_n;
        n_sq        = r_sq;
        n_val       = r_val;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && i_stall;
        n_out_kind  = r_out_kind;
        n_out_val   = r_out_val;
        n_out_bad   = r_out_bad;

        if (r_state == srcc_pkg::ST_IDLE && in_acc) begin
            n_kind = i_kind;
            n_raw  = i_raw_sample;
            n_pc   = 4'd0;
            n_val  = 32'd0;
            n_bad  = 1'b0;
        end

        if (r_state == srcc_pkg::ST_MULW && mul_done) begin
            n_pc = r_pc + 4'd1;
            case (r_kind)
                srcc_pkg::KIND_TEMP: begin
                    case (r_pc)
                        4'd0: n_a = {32'd0, srcc_pkg::asr32(p32, 11)};
                        4'd1: n_b = {32'd0, srcc_pkg::asr32(p32, 12)};
                        4'd2: n_ft = r_a[31:0] + srcc_pkg::asr32(p32, 14);
                        default: n_val = srcc_pkg::asr32(p32 + srcc_pkg::TEMP_RND, 8);
                    endcase
                end
                srcc_pkg::KIND_HUM: begin
                    case (r_pc)
                        4'd0: n_a = {32'd0, srcc_pkg::asr32({2'd0, r_raw[15:0], 14'd0}
                                    - {r_cf_hb[11:0], 20'd0} - p32
                                    + srcc_pkg::HUM_RND_A, 15)};
                        4'd1: n_b = {32'd0, srcc_pkg::asr32(p32, 10)};
                        4'd2: n_c = {32'd0, srcc_pkg::asr32(p32, 11) + srcc_pkg::HUM_OFFS_C};
                        4'd3: n_b = {32'd0, srcc_pkg::asr32(p32, 10) + srcc_pkg::HUM_OFFS_B};
                        4'd4: n_b = {32'd0, srcc_pkg::asr32(p32 + srcc_pkg::HUM_RND_B, 14)};
                        4'd5: begin
                            n_a = {32'd0, p32};
                            n_b = {32'd0, srcc_pkg::asr32(p32, 15)};
                        end
                        4'd6: n_b = {32'd0, srcc_pkg::asr32(p32, 7)};
                        default: begin
                            if (hum_v[31]) begin
                                n_val = 32'd0;
                            end else if (hum_v > srcc_pkg::HUM_MAX) begin
                                n_val = srcc_pkg::HUM_MAX >> 12;
                            end else begin
                                n_val = hum_v >> 12;
                            end
                        end
                    endcase
                end
                default: begin
                    case (r_pc)
                        4'd0: n_sq = mul_prod;
                        4'd1: n_c = mul_prod + {p4[28:0], 35'd0};
                        4'd2: n_c = r_c + {mul_prod[46:0], 17'd0};
                        4'd3: n_a = srcc_pkg::asr64(mul_prod, 8);
                        4'd4: n_a = r_a + {mul_prod[51:0], 12'd0} + srcc_pkg::PRS_BIAS;
                        4'd5: begin
                            n_a = p_div;
                            n_n = {pp[32:0], 31'd0} - r_c;
                            if (p_div == 64'd0) begin
                                n_val = 32'd0;
                                n_bad = 1'b1;
                            end
                        end
                        4'd6: n_n = mul_prod;
                        4'd7: n_b = mul_prod;
                        4'd8: n_b = srcc_pkg::asr64(mul_prod, 25);
                        default: n_c = r_n + r_b + srcc_pkg::asr64(mul_prod, 19);
                    endcase
                end
            endcase
        end

        if (r_state == srcc_pkg::ST_DIVW && div_done) begin
            n_n  = div_q;
            n_sq = srcc_pkg::asr64(div_q, 13);
        end

        if (r_state == srcc_pkg::ST_FIN) begin
            n_val = prs_sat;
        end

        if (out_move) begin
            n_out_valid = 1'b1;
            n_out_kind  = r_kind;
            n_out_val   = r_val;
            n_out_bad   = r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srcc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_ft        <= 32'd0;
            r_pc        <= 4'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_ft        <= n_ft;
            r_pc        <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_raw      <= n_raw;
        r_a        <= n_a;
        r_b        <= n_b;
        r_c        <= n_c;
        r_n        <= n_n;
        r_sq       <= n_sq;
        r_val      <= n_val;
        r_bad      <= n_bad;
        r_out_kind <= n_out_kind;
        r_out_val  <= n_out_val;
        r_out_bad  <= n_out_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cf_t  <= 48'd0;
            r_cf_pa <= 48'd0;
            r_cf_pb <= 48'd0;
            r_cf_pc <= 48'd0;
            r_cf_ha <= 32'd0;
            r_cf_hb <= 40'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                srcc_pkg::REG_TEMP:    r_cf_t  <= i_cfg_data;
                srcc_pkg::REG_PRESS_A: r_cf_pa <= i_cfg_data;
                srcc_pkg::REG_PRESS_B: r_cf_pb <= i_cfg_data;
                srcc_pkg::REG_PRESS_C: r_cf_pc <= i_cfg_data;
                srcc_pkg::REG_HUM_A:   r_cf_ha <= i_cfg_data[31:0];
                srcc_pkg::REG_HUM_B:   r_cf_hb <= i_cfg_data[39:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_measure_kind = r_out_kind;
    assign o_value        = $signed(r_out_val);
    assign o_invalid      = r_out_bad;

    `SRCC_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "busy not raised after accept")
    `SRCC_ASSERT_SAME(a_div_no_mul, r_state == srcc_pkg::ST_DIVW, !mul_start, "multiply issued during divide")
    `SRCC_ASSERT_SAME(a_invalid_zero, o_valid && o_invalid, o_value == 32'sd0 && o_measure_kind == srcc_pkg::KIND_PRESS, "invalid result not zero pressure")
    `SRCC_ASSERT_SAME(a_rsvd_zero, o_valid && o_measure_kind == srcc_pkg::KIND_RSVD, o_value == 32'sd0 && !o_invalid, "reserved kind gave nonzero result")

endmodule
`default_nettype wire

>>> sv/srcc_mul.sv
`default_nettype none
module srcc_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic      [63:0] o_prod
);
    // low 64 bits of a*b from three 32x32 partial products
    logic        r_busy;
    logic [1:0]  r_ph;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic        r_done;
    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] mp;

    always_comb begin
        case (r_ph)
            2'd0:    begin mx = r_a[31:0];  my = r_b[31:0];  end
            2'd1:    begin mx = r_a[31:0];  my = r_b[63:32]; end
            default: begin mx = r_a[63:32]; my = r_b[31:0];  end
        endcase
    end

    assign mp = {32'd0, mx} * {32'd0, my};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= 2'd0;
            end else if (r_busy) begin
                r_ph <= r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_busy) begin
            if (r_ph == 2'd0) begin
                r_acc <= mp;
            end else begin
                r_acc <= r_acc + {mp[31:0], 32'd0};
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule
`default_nettype wire

>>> sv/srcc_div.sv
`default_nettype none
module srcc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_done,
    output logic      [63:0] o_quot
);
    // signed 64-bit divide, truncating, one quotient bit per cycle
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic [63:0] r_rem;
    logic [63:0] r_q;
    logic [63:0] r_den;
    logic [64:0] rem_sh;
    logic [64:0] rem_sub;
    logic        fits;

    assign rem_sh  = {r_rem, r_q[63]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign fits    = !rem_sub[64];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[63] ^ i_den[63];
            r_rem <= 64'd0;
            r_q   <= i_num[63] ? (~i_num + 64'd1) : i_num;
            r_den <= i_den[63] ? (~i_den + 64'd1) : i_den;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[63:0] : rem_sh[63:0];
            r_q   <= {r_q[62:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (~r_q + 64'd1) : r_q;
endmodule
`default_nettype wire

>>> sim/tb_sensor_reading_compensation_core.sv
`default_nettype none
module tb_sensor_reading_compensation_core;

    typedef struct packed {
        logic [1:0]  kind;
        logic [19:0] raw;
    } t_sample;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic        invalid;
    } t_reading;

    localparam int CYCLE_LIMIT = 1200000;
    localparam int DRAIN_CYCLES = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_kind = '0;
    logic [19:0] i_raw_sample = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_measure_kind;
    logic signed [31:0] o_value;
    logic        o_invalid;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;

    sensor_reading_compensation_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_raw_sample(i_raw_sample),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_measure_kind(o_measure_kind), .o_value(o_value), .o_invalid(o_invalid),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [47:0] cal_temp, cal_pa, cal_pb, cal_pc;
    logic [31:0] cal_ha;
    logic [39:0] cal_hb;
    logic [31:0] fine_temp;

    t_sample  sample_q[$];
    t_reading reading_q[$];
    int       errors = 0;
    int       cycles = 0;
    int       n_readings = 0;
    int       n_bad = 0;
    int       n_sat = 0;
    bit       send_hold = 1'b0;
    bit       idle_on = 1'b1;
    int       recv_hold = 0;

    function automatic logic [31:0] sra32(logic [31:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sra64(logic [63:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] quot64(logic [63:0] a, logic [63:0] b);
        logic [63:0] ma, mb, q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic logic [31:0] calc_temp(logic [31:0] adc);
        logic [31:0] t1, t2, t3, x, a, y, b;
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        x = (adc >> 3) - (t1 << 1);
        a = sra32(x * t2, 11);
        y = (adc >> 4) - t1;
        b = sra32(sra32(y * y, 12) * t3, 14);
        fine_temp = a + b;
        return sra32(fine_temp * 32'd5 + 32'd128, 8);
    endfunction

    function automatic logic [31:0] calc_hum(logic [31:0] adc);
        logic [31:0] h1, h2, h3, h4, h5, h6, v, a, b, c, s;
        h1 = {24'd0, cal_ha[7:0]};
        h2 = {{16{cal_ha[23]}}, cal_ha[23:8]};
        h3 = {24'd0, cal_ha[31:24]};
        h4 = {{16{cal_hb[15]}}, cal_hb[15:0]};
        h5 = {{16{cal_hb[31]}}, cal_hb[31:16]};
        h6 = {{24{cal_hb[39]}}, cal_hb[39:32]};
        v = fine_temp - 32'd76800;
        a = sra32((adc << 14) - (h4 << 20) - (h5 * v) + 32'd16384, 15);
        c = sra32(v * h6, 10) * (sra32(v * h3, 11) + 32'd32768);
        b = sra32((sra32(c, 10) + 32'd2097152) * h2 + 32'd8192, 14);
        v = a * b;
        s = sra32(v, 15);
        v = v - sra32(sra32(s * s, 7) * h1, 4);
        if (v[31]) v = 0;
        if (v > 32'd419430400) v = 32'd419430400;
        return v >> 12;
    endfunction

    function automatic logic [31:0] calc_press(logic [31:0] adc, output logic bad);
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, s;
        p1 = {48'd0, cal_pa[15:0]};
        p2 = {{48{cal_pa[31]}}, cal_pa[31:16]};
        p3 = {{48{cal_pa[47]}}, cal_pa[47:32]};
        p4 = {{48{cal_pb[15]}}, cal_pb[15:0]};
        p5 = {{48{cal_pb[31]}}, cal_pb[31:16]};
        p6 = {{48{cal_pb[47]}}, cal_pb[47:32]};
        p7 = {{48{cal_pc[15]}}, cal_pc[15:0]};
        p8 = {{48{cal_pc[31]}}, cal_pc[31:16]};
        p9 = {{48{cal_pc[47]}}, cal_pc[47:32]};
        bad = 1'b0;
        v1 = {{32{fine_temp[31]}}, fine_temp} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 += (v1 * p5) << 17;
        v2 += p4 << 35;
        v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
        if (v1 == 0) begin
            bad = 1'b1;
            return 32'd0;
        end
        p = 64'd1048576 - {32'd0, adc};
        p = quot64(((p << 31) - v2) * 64'd3125, v1);
        s = sra64(p, 13);
        v1 = sra64(p9 * s * s, 25);
        v2 = sra64(p8 * p, 19);
        p = sra64(p + v1 + v2, 8) + (p7 << 4);
        if ($signed(p) < -64'sd2147483648) return 32'h8000_0000;
        if ($signed(p) > 64'sd2147483647) return 32'h7FFF_FFFF;
        return p[31:0];
    endfunction

    function automatic t_reading compensate(t_sample smp);
        t_reading r;
        r.kind = smp.kind;
        r.value = '0;
        r.invalid = 1'b0;
        case (smp.kind)
            srcc_pkg::KIND_TEMP:  r.value = calc_temp({12'd0, smp.raw});
            srcc_pkg::KIND_PRESS: r.value = calc_press({12'd0, smp.raw}, r.invalid);
            srcc_pkg::KIND_HUM:   r.value = calc_hum({16'd0, smp.raw[15:0]});
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] exp_v);
        errors++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, exp_v, cycles);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                reading_q.push_back(compensate({i_kind, i_raw_sample}));
                sample_q.pop_front();
            end
            if (sample_q.size() > 0 && !send_hold
                    && !(idle_on && $urandom_range(99) < 13)) begin
                t_sample nx;
                nx = sample_q[0];
                i_valid <= 1'b1;
                i_kind <= nx.kind;
                i_raw_sample <= nx.raw;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_valid && !i_stall) begin
            if (reading_q.size() == 0) begin
                report("unexpected request", o_value, 0);
            end else begin
                t_reading e;
                e = reading_q.pop_front();
                n_readings++;
                if (e.invalid) n_bad++;
                if (e.kind == srcc_pkg::KIND_PRESS
                        && (e.value == 32'h7FFF_FFFF || e.value == 32'h8000_0000))
                    n_sat++;
                if (o_measure_kind !== e.kind) report("kind", o_measure_kind, e.kind);
                if (o_value !== e.value) report("value", o_value, e.value);
                if (o_invalid !== e.invalid) report("invalid", o_invalid, e.invalid);
            end
        end
        if (recv_hold > 0) begin
            recv_hold--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= idle_on && ($urandom_range(99) < 13);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d", cycles);
            $display("FAIL sensor_reading_compensation_core");
            $finish;
        end
    end

    task automatic wait_idle();
        while (sample_q.size() != 0 || i_valid || reading_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            srcc_pkg::REG_TEMP:    cal_temp = data;
            srcc_pkg::REG_PRESS_A: cal_pa = data;
            srcc_pkg::REG_PRESS_B: cal_pb = data;
            srcc_pkg::REG_PRESS_C: cal_pc = data;
            srcc_pkg::REG_HUM_A:   cal_ha = data[31:0];
            srcc_pkg::REG_HUM_B:   cal_hb = data[39:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [47:0] rnd48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // typical calibration with random jitter on the low bits
    task automatic load_typical();
        write_reg(srcc_pkg::REG_TEMP,
                  {16'd50, 16'd26435, 16'd27504} ^ 48'($urandom_range(255)));
        write_reg(srcc_pkg::REG_PRESS_A,
                  {16'hF4F5 ^ 16'($urandom_range(63)), 16'hD5F2, 16'd36477});
        write_reg(srcc_pkg::REG_PRESS_B,
                  {16'd23, 16'd140 ^ 16'($urandom_range(63)), 16'd2855});
        write_reg(srcc_pkg::REG_PRESS_C,
                  {16'd6000, 16'hC1B4, 16'd15500 ^ 16'($urandom_range(255))});
        write_reg(srcc_pkg::REG_HUM_A, {16'd0, 8'd0, 16'd363, 8'd75});
        write_reg(srcc_pkg::REG_HUM_B, {8'd0, 8'd30, 16'd50, 16'd313});
    endtask

    task automatic push(logic [1:0] k, logic [19:0] r);
        sample_q.push_back('{kind: k, raw: r});
    endtask

    task automatic push_random(int n);
        int choice;
        for (int i = 0; i < n; i++) begin
            choice = $urandom_range(99);
            if (choice < 30) push(srcc_pkg::KIND_TEMP, 20'($urandom_range(400000, 600000)));
            else if (choice < 60)
                push(srcc_pkg::KIND_PRESS, 20'($urandom_range(250000, 450000)));
            else if (choice < 85) push(srcc_pkg::KIND_HUM, 20'($urandom_range(20000, 40000)));
            else if (choice < 95) push(2'($urandom_range(2)), 20'($urandom()));
            else push(srcc_pkg::KIND_RSVD, 20'($urandom()));
        end
    endtask

    initial begin
        cal_temp = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0;
        cal_ha = '0; cal_hb = '0; fine_temp = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero coefficients: pressure divisor is zero
        push(srcc_pkg::KIND_PRESS, 20'd0);
        push(srcc_pkg::KIND_HUM, 20'hFFFFF);
        push(srcc_pkg::KIND_TEMP, 20'hFFFFF);
        push(srcc_pkg::KIND_RSVD, 20'hFFFFF);
        wait_idle();

        load_typical();
        write_reg(3'd6, rnd48());
        write_reg(3'd7, rnd48());
        push(srcc_pkg::KIND_TEMP, 20'd0);
        push(srcc_pkg::KIND_PRESS, 20'd0);
        push(srcc_pkg::KIND_HUM, 20'd0);
        push(srcc_pkg::KIND_TEMP, 20'hFFFFF);
        push(srcc_pkg::KIND_PRESS, 20'hFFFFF);
        push(srcc_pkg::KIND_HUM, 20'hFFFFF);
        push(srcc_pkg::KIND_TEMP, 20'd519888);
        push(srcc_pkg::KIND_PRESS, 20'd415148);
        push(srcc_pkg::KIND_HUM, 20'd30000);
        push(srcc_pkg::KIND_RSVD, 20'h55555);
        push(srcc_pkg::KIND_PRESS, 20'hAAAAA);
        push(srcc_pkg::KIND_HUM, 20'h0FFFF);
        wait_idle();

        // extreme coefficients, saturation and clamping
        write_reg(srcc_pkg::REG_TEMP, 48'hFFFF_FFFF_FFFF);
        write_reg(srcc_pkg::REG_PRESS_A, 48'h7FFF_7FFF_FFFF);
        write_reg(srcc_pkg::REG_PRESS_B, 48'h8000_7FFF_8000);
        write_reg(srcc_pkg::REG_PRESS_C, 48'h7FFF_8000_7FFF);
        write_reg(srcc_pkg::REG_HUM_A, 48'hFF80_00FF);
        write_reg(srcc_pkg::REG_HUM_B, 48'h80_7FFF_8000);
        push(srcc_pkg::KIND_TEMP, 20'd12345);
        push(srcc_pkg::KIND_PRESS, 20'd0);
        push(srcc_pkg::KIND_HUM, 20'hFFFF);
        push(srcc_pkg::KIND_PRESS, 20'hFFFFF);
        push(srcc_pkg::KIND_TEMP, 20'hFFFFF);
        push(srcc_pkg::KIND_HUM, 20'd0);
        push(srcc_pkg::KIND_PRESS, 20'd1);
        wait_idle();

        // long receiver hold while sender keeps offering
        load_typical();
        idle_on = 1'b0;
        recv_hold = 400;
        push_random(40);
        wait_idle();

        // sender pause with samples queued, then drain
        send_hold = 1'b1;
        push_random(10);
        repeat (50) @(posedge i_clk);
        send_hold = 1'b0;
        wait_idle();
        idle_on = 1'b1;

        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 2) begin
                for (int r = 0; r < 6; r++) write_reg(3'(r), rnd48());
            end else begin
                load_typical();
            end
            push_random(210);
            wait_idle();
        end

        $display("checked %0d readings: %0d invalid pressure, %0d saturated pressure",
                 n_readings, n_bad, n_sat);
        $display("covered zero divisor, extreme coefficients, reserved kind, stalls");
        if (errors == 0 && reading_q.size() == 0) begin
            $display("PASS sensor_reading_compensation_core");
        end else begin
            $display("FAIL sensor_reading_compensation_core");
        end
        $finish;
    end
endmodule
`default_nettype wire
